// ----- rtl/i2cseq_pkg.sv -----
// Shared types and constants for the I2C transaction sequencer.
`timescale 1ns / 1ps

package i2cseq_pkg;

  localparam int unsigned DEF_BUFFER_DEPTH = 32;
  localparam int unsigned BUF_ADDR_W       = 6;

  localparam logic [2:0] OP_LOAD_MASTER  = 3'd0;
  localparam logic [2:0] OP_START_WRITE  = 3'd1;
  localparam logic [2:0] OP_START_READ   = 3'd2;
  localparam logic [2:0] OP_BUS_STATUS   = 3'd3;
  localparam logic [2:0] OP_READ_MASTER  = 3'd4;
  localparam logic [2:0] OP_WRITE_SLAVE  = 3'd5;

  localparam logic [7:0] STATUS_MASK     = 8'hF8;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RESTART      = 8'h10;
  localparam logic [7:0] ST_MT_ADDR_ACK  = 8'h18;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MR_ADDR_ACK  = 8'h40;
  localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;
  localparam logic [7:0] ST_SR_ADDR_ACK  = 8'h60;
  localparam logic [7:0] ST_SR_DATA_ACK  = 8'h80;
  localparam logic [7:0] ST_SR_DATA_NACK = 8'h88;
  localparam logic [7:0] ST_SR_STOP      = 8'hA0;
  localparam logic [7:0] ST_ST_ADDR_ACK  = 8'hA8;
  localparam logic [7:0] ST_ST_DATA_ACK  = 8'hB8;
  localparam logic [7:0] ST_ST_DATA_NACK = 8'hC0;
  localparam logic [7:0] ST_ST_LAST_ACK  = 8'hC8;

  localparam logic [1:0] ACK_KEEP  = 2'd0;
  localparam logic [1:0] ACK_SET   = 2'd1;
  localparam logic [1:0] ACK_CLEAR = 2'd2;

  localparam logic [2:0] EV_NONE         = 3'd0;
  localparam logic [2:0] EV_NACK         = 3'd1;
  localparam logic [2:0] EV_TX_DONE      = 3'd2;
  localparam logic [2:0] EV_MASTER_READY = 3'd3;
  localparam logic [2:0] EV_SLAVE_READY  = 3'd4;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_BUSY  = 2'd1;
  localparam logic [1:0] ERR_COUNT = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] address;
    logic [5:0] count;
    logic [4:0] index;
    logic [7:0] data_byte;
    logic [7:0] status;
  } cmd_word_t;

  typedef struct packed {
    logic       start_request;
    logic       start_clear;
    logic       stop_request;
    logic [1:0] ack_action;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] event_res;
    logic [5:0] event_count;
    logic       busy_res;
    logic [1:0] error;
    logic [7:0] read_byte;
  } res_word_t;

  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic [BUF_ADDR_W-1:0] wr_addr;
    logic [BUF_ADDR_W-1:0] rd_addr;
    logic [7:0]            wr_data;
  } buf_req_t;

endpackage

// ----- rtl/i2cseq_if.sv -----
// Valid/ready channel interfaces for command and result words.
`timescale 1ns / 1ps

interface i2cseq_cmd_if;
  import i2cseq_pkg::*;
  logic      valid;
  logic      ready;
  cmd_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cseq_res_if;
  import i2cseq_pkg::*;
  logic      valid;
  logic      ready;
  res_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/i2cseq_buf.sv -----
// Byte buffer: one write port, one registered read port.
`timescale 1ns / 1ps

module i2cseq_buf
  import i2cseq_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_BUFFER_DEPTH
) (
  input  logic       clk,
  input  buf_req_t   req,
  output logic [7:0] rd_data
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

// ----- rtl/i2c_transaction_sequencer_core.sv -----
// Top level of the I2C byte-level transaction sequencer.
//
// Channels: cmd takes one command or bus status word per handshake
// (valid && ready); res returns exactly one result word for each.
// cfg_wr_en/cfg_wr_data write the slave_enabled register at any clock edge
// where cfg_wr_en is high; write it only while no word is in flight.
// A word accepted on cmd is held in the input register, and its result in
// the result register, which drives res. Throughput is one word per cycle
// unless res stalls; master and slave buffers each have one write and one
// registered read port, so every word touches each buffer at most once.
// Reset (rst, synchronous) empties both pipeline registers, clears the
// master and slave position/length/address state and slave_enabled. The
// buffer contents are not cleared; an entry reads back as written.
// When res.ready is low the result register holds; one more word is still
// taken into the input register if it is empty, after which cmd.ready drops
// until the result is taken.
`timescale 1ns / 1ps

module i2c_transaction_sequencer_core
  import i2cseq_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  i2cseq_cmd_if.sink          cmd,
  i2cseq_res_if.source        res,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  localparam int unsigned PW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);
  localparam logic [6:0]    DEPTH_W = 7'(BUFFER_DEPTH);

  typedef enum logic [1:0] {TX_REG, TX_MBUF, TX_SBUF} tx_sel_t;

  // pipeline
  logic      a_valid;
  cmd_word_t a_word;
  logic      b_valid;
  res_word_t res_q;
  tx_sel_t   tx_sel;
  logic      rb_mem;
  logic      advance;
  logic      fire;

  // sequencer state
  logic          slave_en;
  logic [5:0]    mp, mp_next;
  logic [5:0]    ml, ml_next;
  logic [7:0]    mab, mab_next;
  logic [PW-1:0] sp, sp_next;
  logic [PW-1:0] sl, sl_next;

  res_word_t res_next;
  tx_sel_t   tx_sel_next;
  logic      rb_mem_next;
  buf_req_t  mreq, sreq;
  logic [7:0] m_rd, s_rd;

  logic [7:0]    code;
  logic [5:0]    mp_inc;
  logic [6:0]    mp_w, ml_w, mp_inc_w, idx_w, cnt_w;
  logic [PW-1:0] spn;
  logic [6:0]    sp_w, spn_w, sl_w;
  logic          mbusy;

  assign advance   = !b_valid || res.ready;
  assign fire      = a_valid && advance;
  assign cmd.ready = !a_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      a_word <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      slave_en <= 1'b0;
      mp       <= '0;
      ml       <= '0;
      mab      <= '0;
      sp       <= '0;
      sl       <= '0;
    end else begin
      if (cfg_wr_en) begin
        slave_en <= cfg_wr_data;
      end
      if (advance) begin
        b_valid <= a_valid;
      end
      if (fire) begin
        mp  <= mp_next;
        ml  <= ml_next;
        mab <= mab_next;
        sp  <= sp_next;
        sl  <= sl_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q  <= res_next;
      tx_sel <= tx_sel_next;
      rb_mem <= rb_mem_next;
    end
  end

  assign code     = a_word.status & STATUS_MASK;
  assign mp_inc   = mp + 6'd1;
  assign mp_w     = {1'b0, mp};
  assign ml_w     = {1'b0, ml};
  assign mp_inc_w = {1'b0, mp_inc};
  assign idx_w    = {2'b00, a_word.index};
  assign cnt_w    = {1'b0, a_word.count};
  assign sp_w     = 7'(sp);
  assign sl_w     = 7'(sl);
  assign spn_w    = 7'(spn);
  assign mbusy    = (mab != 8'd0) || (mp != 6'd0);

  // slave position after this word, for the three codes that step it
  always_comb begin
    spn = sp;
    if (code == ST_SR_DATA_ACK || code == ST_SR_DATA_NACK) begin
      if (sp < sl) begin
        spn = sp + PW'(1);
      end
    end else if (sp < DEPTH_P) begin
      spn = sp + PW'(1);
    end
  end

  always_comb begin
    mp_next     = mp;
    ml_next     = ml;
    mab_next    = mab;
    sp_next     = sp;
    sl_next     = sl;
    res_next    = '0;
    tx_sel_next = TX_REG;
    rb_mem_next = 1'b0;
    mreq        = '0;
    sreq        = '0;
    mreq.wr_data = a_word.data_byte;
    sreq.wr_data = a_word.data_byte;

    unique case (a_word.op)
      OP_LOAD_MASTER: begin
        if (mbusy) begin
          res_next.error = ERR_BUSY;
        end else if (idx_w < DEPTH_W) begin
          mreq.wr_en   = fire;
          mreq.wr_addr = idx_w[5:0];
        end
      end
      OP_START_WRITE, OP_START_READ: begin
        if (mbusy) begin
          res_next.error = ERR_BUSY;
        end else if (cnt_w > DEPTH_W) begin
          res_next.error = ERR_COUNT;
        end else begin
          mab_next = {a_word.address, a_word.op == OP_START_READ};
          mp_next  = '0;
          ml_next  = a_word.count;
          res_next.start_request = 1'b1;
        end
      end
      OP_READ_MASTER: begin
        if (idx_w < DEPTH_W) begin
          mreq.rd_en   = fire;
          mreq.rd_addr = idx_w[5:0];
          rb_mem_next  = 1'b1;
        end else begin
          res_next.read_byte = 8'hFF;
        end
      end
      OP_WRITE_SLAVE: begin
        if (idx_w < DEPTH_W) begin
          sreq.wr_en   = fire;
          sreq.wr_addr = idx_w[5:0];
        end
      end
      OP_BUS_STATUS: begin
        unique case (code)
          ST_START, ST_RESTART: begin
            res_next.start_clear = 1'b1;
            res_next.tx_valid    = 1'b1;
            res_next.tx_byte     = mab;
          end
          ST_MT_ADDR_ACK, ST_MT_DATA_ACK: begin
            if (mp < ml) begin
              res_next.tx_valid = 1'b1;
              if (mp_w < DEPTH_W) begin
                mreq.rd_en   = fire;
                mreq.rd_addr = mp;
                tx_sel_next  = TX_MBUF;
              end else begin
                res_next.tx_byte = 8'hFF;
              end
              mp_next = mp_inc;
            end else begin
              res_next.stop_request = 1'b1;
              res_next.event_res    = EV_TX_DONE;
              mab_next = '0;
              mp_next  = '0;
              ml_next  = '0;
            end
          end
          ST_MR_ADDR_ACK: begin
            res_next.ack_action = ACK_SET;
          end
          ST_MR_DATA_ACK, ST_MR_DATA_NACK: begin
            if (mp_w < DEPTH_W) begin
              mreq.wr_en   = fire;
              mreq.wr_addr = mp;
            end
            mp_next = mp_inc;
            res_next.ack_action = ACK_CLEAR;
            if (mp_inc == ml) begin
              res_next.stop_request = 1'b1;
              res_next.event_res    = EV_MASTER_READY;
              res_next.event_count  = mp_inc;
              mab_next = '0;
              mp_next  = '0;
              ml_next  = '0;
              if (slave_en) begin
                res_next.ack_action = ACK_SET;
              end
            end else if ((mp_inc_w + 7'd1) < ml_w) begin
              res_next.ack_action = ACK_SET;
            end
          end
          ST_SR_ADDR_ACK: begin
            sl_next = DEPTH_P;
            sp_next = '0;
          end
          ST_SR_DATA_ACK, ST_SR_DATA_NACK: begin
            if (sp < sl && sp < DEPTH_P) begin
              sreq.wr_en   = fire;
              sreq.wr_addr = sp_w[5:0];
            end
            sp_next = spn;
            if ({1'b0, spn_w} + 8'd1 >= {1'b0, sl_w}) begin
              res_next.ack_action = ACK_CLEAR;
            end
          end
          ST_SR_STOP: begin
            res_next.event_res   = EV_SLAVE_READY;
            res_next.event_count = sp_w[5:0];
            res_next.ack_action  = ACK_SET;
            sp_next = '0;
            sl_next = '0;
          end
          ST_ST_ADDR_ACK: begin
            sl_next = DEPTH_P;
            sp_next = '0;
            res_next.tx_valid = 1'b1;
            sreq.rd_en   = fire;
            sreq.rd_addr = '0;
            tx_sel_next  = TX_SBUF;
          end
          ST_ST_DATA_ACK: begin
            sp_next = spn;
            res_next.tx_valid = 1'b1;
            if (spn < DEPTH_P) begin
              sreq.rd_en   = fire;
              sreq.rd_addr = spn_w[5:0];
              tx_sel_next  = TX_SBUF;
            end else begin
              res_next.tx_byte = 8'hFF;
            end
            if ({1'b0, spn_w} + 8'd1 >= {1'b0, sl_w}) begin
              res_next.ack_action = ACK_CLEAR;
            end
          end
          ST_ST_DATA_NACK, ST_ST_LAST_ACK: begin
            res_next.ack_action = ACK_SET;
          end
          default: begin
            // unexpected status: abort any master transfer
            if (mab != 8'd0) begin
              res_next.start_clear  = 1'b1;
              res_next.stop_request = 1'b1;
              res_next.event_res    = EV_NACK;
              mab_next = '0;
              mp_next  = '0;
              ml_next  = '0;
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    res_next.busy_res = (mab_next != 8'd0) || (mp_next != 6'd0);
  end

  i2cseq_buf #(
    .DEPTH (BUFFER_DEPTH)
  ) u_master_buf (
    .clk     (clk),
    .req     (mreq),
    .rd_data (m_rd)
  );

  i2cseq_buf #(
    .DEPTH (BUFFER_DEPTH)
  ) u_slave_buf (
    .clk     (clk),
    .req     (sreq),
    .rd_data (s_rd)
  );

  always_comb begin
    res.data = res_q;
    unique case (tx_sel)
      TX_MBUF: res.data.tx_byte = m_rd;
      TX_SBUF: res.data.tx_byte = s_rd;
      default: res.data.tx_byte = res_q.tx_byte;
    endcase
    if (rb_mem) begin
      res.data.read_byte = m_rd;
    end
  end

  assign res.valid = b_valid;

`ifndef SYNTH
  a_busy_matches_state: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> res_q.busy_res == ((mab != 8'd0) || (mp != 6'd0)))
    else $error("busy_res disagrees with master state");

  a_error_no_action: assert property (@(posedge clk) disable iff (rst)
    (b_valid && res_q.error != ERR_OK) |-> (!res_q.start_request && !res_q.tx_valid))
    else $error("rejected command produced bus action");

  a_nack_aborts: assert property (@(posedge clk) disable iff (rst)
    (b_valid && res_q.event_res == EV_NACK) |->
      (res_q.start_clear && res_q.stop_request && !res_q.busy_res))
    else $error("nack without abort");

  a_slave_pos_range: assert property (@(posedge clk) disable iff (rst)
    sp <= DEPTH_P)
    else $error("slave position past buffer depth");
`endif

endmodule
